[rtl/bcd_add_subtract_defines.svh]
// ----------------------------------------------------------------------------
// BCD adder/subtractor assertion macros
// Shared property forms for the checks in the BCD add/subtract block.
// ----------------------------------------------------------------------------
`ifndef BCD_ADD_SUBTRACT_DEFINES_SVH
`define BCD_ADD_SUBTRACT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDAS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcd_add_subtract: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCDAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcd_add_subtract: next-cycle check failed");

`endif

[rtl/bcdas_pkg.sv]
// ----------------------------------------------------------------------------
// BCD add/subtract package
// Widths, status codes and item types shared by the digit cells and the top.
// ----------------------------------------------------------------------------
package bcdas_pkg;

    // Number of digit positions handled by the block (1 to 16).
    localparam int DIGITS  = 16;
    localparam int NIB_W   = 4;
    localparam int MAX_DIG = 16;
    localparam int DATA_W  = NIB_W * MAX_DIG;
    localparam int LEN_W   = 5;
    // Results enter each cell chain at the top nibble; this realigns them.
    localparam int ALIGN_SHIFT = NIB_W * (MAX_DIG - DIGITS);

    localparam logic [LEN_W-1:0] DIGITS_LEN = LEN_W'(DIGITS);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DIGIT = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] a_digits;
        logic [LEN_W-1:0]  a_len;
        logic [DATA_W-1:0] b_digits;
        logic [LEN_W-1:0]  b_len;
    } bcdas_op_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] sum_digits;
        logic              sum_carry;
        logic [LEN_W-1:0]  sum_len;
        logic [DATA_W-1:0] diff_digits;
        logic [LEN_W-1:0]  diff_len;
        logic              diff_negative;
    } bcdas_res_t;

    // Work in flight between two neighboring cells.
    typedef struct packed {
        logic [DATA_W-1:0] a_dig;
        logic [DATA_W-1:0] b_dig;
        logic [LEN_W-1:0]  a_rem;
        logic [LEN_W-1:0]  b_rem;
        logic [LEN_W-1:0]  m_rem;
        logic [LEN_W-1:0]  pos;
        logic              a_len_bad;
        logic              a_bad;
        logic              b_len_bad;
        logic              b_bad;
        logic [LEN_W-1:0]  max_len;
        logic              carry;
        logic              carry_top;
        logic [DATA_W-1:0] sum;
        logic              borrow_ab;
        logic [DATA_W-1:0] diff_ab;
        logic [LEN_W-1:0]  dlen_ab;
        logic              borrow_ba;
        logic [DATA_W-1:0] diff_ba;
        logic [LEN_W-1:0]  dlen_ba;
    } bcdas_stage_t;

endpackage

[rtl/bcdas_cell.sv]
// ----------------------------------------------------------------------------
// BCD add/subtract digit cell
// Works one decimal digit of an item and hands the item to the next cell.
// ----------------------------------------------------------------------------
module bcdas_cell
    import bcdas_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic         up_valid,
    input  bcdas_stage_t up_item,
    output logic         valid,
    output bcdas_stage_t item
);

    logic         valid_reg;
    bcdas_stage_t item_reg;
    bcdas_stage_t item_next;

    // One decimal digit of x minus (y plus borrow in); returns {borrow, digit}.
    function automatic logic [NIB_W:0] sub_digit(input logic [NIB_W-1:0] x,
                                                 input logic [NIB_W-1:0] y,
                                                 input logic             bin);
        logic [NIB_W:0] xe;
        logic [NIB_W:0] ye;
        xe = {1'b0, x};
        ye = {1'b0, y} + {{NIB_W{1'b0}}, bin};
        if (xe < ye)
        begin
            sub_digit = {1'b1, NIB_W'(xe + (NIB_W+1)'(10) - ye)};
        end
        else
        begin
            sub_digit = {1'b0, NIB_W'(xe - ye)};
        end
    endfunction

    always_comb
    begin
        logic [NIB_W-1:0] ad;
        logic [NIB_W-1:0] bd;
        logic [NIB_W:0]   s;
        logic [NIB_W-1:0] sd;
        logic             c;
        logic [NIB_W:0]   dab;
        logic [NIB_W:0]   dba;

        item_next = up_item;

        // Digits at or above an operand's length count as zero.
        ad = (up_item.a_rem != '0) ? up_item.a_dig[NIB_W-1:0] : '0;
        bd = (up_item.b_rem != '0) ? up_item.b_dig[NIB_W-1:0] : '0;

        item_next.a_dig = up_item.a_dig >> NIB_W;
        item_next.b_dig = up_item.b_dig >> NIB_W;
        item_next.a_rem = (up_item.a_rem != '0) ? up_item.a_rem - 1'b1 : '0;
        item_next.b_rem = (up_item.b_rem != '0) ? up_item.b_rem - 1'b1 : '0;
        item_next.m_rem = (up_item.m_rem != '0) ? up_item.m_rem - 1'b1 : '0;
        item_next.pos   = up_item.pos + 1'b1;

        item_next.a_bad = up_item.a_bad |
                          ((up_item.a_rem != '0) && (up_item.a_dig[NIB_W-1:0] > 4'd9));
        item_next.b_bad = up_item.b_bad |
                          ((up_item.b_rem != '0) && (up_item.b_dig[NIB_W-1:0] > 4'd9));

        s = {1'b0, ad} + {1'b0, bd} + {{NIB_W{1'b0}}, up_item.carry};
        if (s > (NIB_W+1)'(9))
        begin
            sd = NIB_W'(s - (NIB_W+1)'(10));
            c  = 1'b1;
        end
        else
        begin
            sd = NIB_W'(s);
            c  = 1'b0;
        end
        item_next.carry = c;
        item_next.sum   = {sd, up_item.sum[DATA_W-1:NIB_W]};
        if (up_item.m_rem == LEN_W'(1))
        begin
            item_next.carry_top = c;
        end

        dab = sub_digit(ad, bd, up_item.borrow_ab);
        dba = sub_digit(bd, ad, up_item.borrow_ba);
        item_next.borrow_ab = dab[NIB_W];
        item_next.borrow_ba = dba[NIB_W];
        item_next.diff_ab   = {dab[NIB_W-1:0], up_item.diff_ab[DATA_W-1:NIB_W]};
        item_next.diff_ba   = {dba[NIB_W-1:0], up_item.diff_ba[DATA_W-1:NIB_W]};
        if (dab[NIB_W-1:0] != '0)
        begin
            item_next.dlen_ab = up_item.pos + 1'b1;
        end
        if (dba[NIB_W-1:0] != '0)
        begin
            item_next.dlen_ba = up_item.pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

[rtl/bcd_add_subtract.sv]
// ----------------------------------------------------------------------------
// BCD add/subtract
// Adds two packed BCD numbers and gives the magnitude and sign of their
// difference, one decimal digit per cell along a chain of cells.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                        Direction   Carries
//   op        op_valid, op_stall, op_item    in          two operands
//   res       res_valid, res_stall, res_item out         sum, difference
//
// Each item passes through every digit cell in turn and then through the
// result register between acceptance and its result being shown on res.
// The chain takes a new item every cycle unless res stalls, so the sustained
// rate is one item per cycle; the digit cells set the latency, not the rate.
// Reset clears the valid bits of the cells and of the result register only.
// A stall on res holds the result; empty cells still close up behind it, so
// op_stall rises only when every cell and the result register hold an item.
// ----------------------------------------------------------------------------
`include "bcd_add_subtract_defines.svh"

module bcd_add_subtract
    import bcdas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       op_valid,
    output logic       op_stall,
    input  bcdas_op_t  op_item,
    output logic       res_valid,
    input  logic       res_stall,
    output bcdas_res_t res_item
);

    bcdas_stage_t front;
    bcdas_stage_t cell_item  [DIGITS];
    logic         cell_valid [DIGITS];
    // load[k] lets cell k take a new item; load[DIGITS] is the result register.
    logic         load [DIGITS+1];

    logic         res_valid_reg;
    bcdas_res_t   res_item_reg;
    bcdas_res_t   res_item_next;

    // The length checks and the leading zero test need the whole operand, so
    // they are done once in front of the first cell. The cells then only
    // collect illegal digits along with the arithmetic.
    always_comb
    begin
        logic a_lz;
        logic b_lz;

        a_lz = 1'b0;
        b_lz = 1'b0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if ((op_item.a_len == LEN_W'(i + 1)) &&
                (op_item.a_digits[NIB_W*i +: NIB_W] == '0))
            begin
                a_lz = 1'b1;
            end
            if ((op_item.b_len == LEN_W'(i + 1)) &&
                (op_item.b_digits[NIB_W*i +: NIB_W] == '0))
            begin
                b_lz = 1'b1;
            end
        end

        front.a_dig     = op_item.a_digits;
        front.b_dig     = op_item.b_digits;
        front.a_rem     = op_item.a_len;
        front.b_rem     = op_item.b_len;
        front.max_len   = (op_item.a_len > op_item.b_len) ? op_item.a_len : op_item.b_len;
        front.m_rem     = front.max_len;
        front.pos       = '0;
        front.a_len_bad = (op_item.a_len == '0) || (op_item.a_len > DIGITS_LEN);
        front.b_len_bad = (op_item.b_len == '0) || (op_item.b_len > DIGITS_LEN);
        front.a_bad     = a_lz;
        front.b_bad     = b_lz;
        front.carry     = 1'b0;
        front.carry_top = 1'b0;
        front.sum       = '0;
        front.borrow_ab = 1'b0;
        front.diff_ab   = '0;
        front.dlen_ab   = LEN_W'(1);
        front.borrow_ba = 1'b0;
        front.diff_ba   = '0;
        front.dlen_ba   = LEN_W'(1);
    end

    // A stage may load when it is empty or when its item moves on in the
    // same cycle, which lets bubbles close up under a stalled output.
    always_comb
    begin
        load[DIGITS] = !res_valid_reg || !res_stall;
        for (int k = DIGITS - 1; k >= 0; k--)
        begin
            load[k] = !cell_valid[k] || load[k+1];
        end
    end

    assign op_stall = !load[0];

    generate
        for (genvar k = 0; k < DIGITS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_first
                bcdas_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (load[k]),
                    .up_valid (op_valid),
                    .up_item  (front),
                    .valid    (cell_valid[k]),
                    .item     (cell_item[k])
                );
            end
            else
            begin : g_next
                bcdas_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .load     (load[k]),
                    .up_valid (cell_valid[k-1]),
                    .up_item  (cell_item[k-1]),
                    .valid    (cell_valid[k]),
                    .item     (cell_item[k])
                );
            end
        end
    endgenerate

    // The final borrow of A minus B tells whether A is the smaller operand;
    // the other chain then already holds the magnitude B minus A.
    always_comb
    begin
        bcdas_stage_t t;
        logic [1:0]   st;

        t = cell_item[DIGITS-1];
        if (t.a_len_bad)
        begin
            st = ST_EMPTY;
        end
        else if (t.a_bad)
        begin
            st = ST_DIGIT;
        end
        else if (t.b_len_bad)
        begin
            st = ST_EMPTY;
        end
        else if (t.b_bad)
        begin
            st = ST_DIGIT;
        end
        else
        begin
            st = ST_OK;
        end

        res_item_next = '0;
        res_item_next.status = st;
        if (st == ST_OK)
        begin
            res_item_next.sum_digits    = t.sum >> ALIGN_SHIFT;
            res_item_next.sum_carry     = t.carry;
            res_item_next.sum_len       = t.max_len + {{(LEN_W-1){1'b0}}, t.carry_top};
            res_item_next.diff_negative = t.borrow_ab;
            res_item_next.diff_digits   = (t.borrow_ab ? t.diff_ba : t.diff_ab) >> ALIGN_SHIFT;
            res_item_next.diff_len      = t.borrow_ab ? t.dlen_ba : t.dlen_ab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load[DIGITS])
        begin
            res_valid_reg <= cell_valid[DIGITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[DIGITS] && cell_valid[DIGITS-1])
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // An empty first cell must always take a new item.
    `BCDAS_ASSERT_SAME(a_first_cell_open, !cell_valid[0], !op_stall)
    // A rejected operand leaves every arithmetic field at zero.
    `BCDAS_ASSERT_SAME(a_error_clears,
        res_valid && (res_item.status != ST_OK),
        (res_item.sum_digits == '0) && (res_item.diff_digits == '0) &&
        (res_item.sum_len == '0) && (res_item.diff_len == '0) &&
        !res_item.sum_carry && !res_item.diff_negative)
    // Good results always have nonzero lengths.
    `BCDAS_ASSERT_SAME(a_lengths_set,
        res_valid && (res_item.status == ST_OK),
        (res_item.sum_len != '0) && (res_item.diff_len != '0))
    // A negative difference cannot have a zero magnitude.
    `BCDAS_ASSERT_SAME(a_negative_nonzero,
        res_valid && (res_item.status == ST_OK) && res_item.diff_negative,
        res_item.diff_digits != '0)
    // A full chain under a held result keeps refusing new items.
    `BCDAS_ASSERT_NEXT(a_full_holds,
        op_stall && res_stall,
        op_stall || !res_stall)

endmodule
